### hw/rtl/fds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_pkg
// Shared codes, field widths and the result type of the docking sequencer.
// ----------------------------------------------------------------------------
package fds_pkg;

	// Field widths
	localparam int OP_W    = 2;
	localparam int MODE_W  = 2;
	localparam int ANGLE_W = 16;
	localparam int DIST_W  = 16;
	localparam int RATE_W  = 15;
	localparam int TOL_W   = 16;
	localparam int SCALE_W = 13;
	localparam int THR_W   = 16;
	localparam int FWD_W   = 15;
	localparam int TURN_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Request opcodes
	localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_W-1:0] OP_ENABLE  = 2'd1;
	localparam logic [OP_W-1:0] OP_MEASURE = 2'd2;

	// Modes
	localparam logic [MODE_W-1:0] MODE_APPROACH  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DOCKED    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CENTERING = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DISABLED  = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOLERANCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DOCK_THRESHOLD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_APPROACH_RATE   = 3'd4;

	// Register reset values
	localparam logic [RATE_W-1:0]  RST_TURN_RATE       = 15'd6144;
	localparam logic [TOL_W-1:0]   RST_ANGLE_TOLERANCE = 16'd40960;
	localparam logic [SCALE_W-1:0] RST_DISTANCE_SCALE  = 13'd2048;
	localparam logic [THR_W-1:0]   RST_DOCK_THRESHOLD  = 16'd205;
	localparam logic [RATE_W-1:0]  RST_APPROACH_RATE   = 15'd8192;

	// Divider quotient lengths: steering quotient is kept to 17 bits after
	// an up-front overflow check, forward quotient always fits 15 bits.
	localparam int STEER_QB = 17;
	localparam int FWD_QB   = 15;
	localparam int CNT_W    = 5;

	// Width of every product of the shared multiplier
	localparam int PROD_W = 31;

	// One tick result
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [FWD_W-1:0]  fwd;
		logic [TURN_W-1:0] turn;
		logic              cv;
	} res_t;

endpackage

### hw/rtl/fiducial_docking_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fiducial_docking_sequencer_core
// Docking mode sequencer: centering, approach, docked and disabled modes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: a tick, an
//   enable event or a marker measurement. Enable events and measurements
//   update state in the accept cycle and produce no result. A tick produces
//   one result on the output channel (out_valid / out_stall).
//   Work of a tick: disabled, docked and centering without a marker need
//   no arithmetic; centering with a marker checks the angle against the
//   window; approach runs three multiplies, a 17-step steering division
//   (skipped when the steering value is zero or saturates up front) and a
//   15-step forward division, all on one multiplier and one subtractor.
//   Reset: mode disabled, held marker cleared, registers to their defaults.
//   in_stall is high while a tick is being worked, so one tick is in flight
//   at a time; other requests are taken every cycle while idle.
//   The result sits in an output register; the next request is accepted
//   while it waits. When out_stall holds the register, a following tick
//   finishes its arithmetic and then waits until the register frees.
//   Configuration is written through cfg_we / cfg_index / cfg_data; the user
//   must write it only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fiducial_docking_sequencer_core
	import fds_pkg::*;
#(
	parameter int FRAC_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [OP_W-1:0]       op,
	input  logic                  enable_flag,
	input  logic signed [ANGLE_W-1:0] marker_angle,
	input  logic [DIST_W-1:0]     marker_distance,
	input  logic                  marker_seen,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [MODE_W-1:0]     mode,
	output logic [FWD_W-1:0]      forward_speed,
	output logic signed [TURN_W-1:0] turn_speed,
	output logic                  command_valid
);

	// Widths following from the fraction length
	localparam int DEN_W = ((29 > TOL_W + FRAC_BITS) ? 29 : TOL_W + FRAC_BITS) + 1;
	localparam int SUB_W = DEN_W + 1;
	localparam int NUM_W = PROD_W + FRAC_BITS;

	// Sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL1 = 4'd1;
	localparam logic [3:0] ST_DEN  = 4'd2;
	localparam logic [3:0] ST_CMP  = 4'd3;
	localparam logic [3:0] ST_OVF  = 4'd4;
	localparam logic [3:0] ST_SDIV = 4'd5;
	localparam logic [3:0] ST_SSAT = 4'd6;
	localparam logic [3:0] ST_FSET = 4'd7;
	localparam logic [3:0] ST_FDIV = 4'd8;
	localparam logic [3:0] ST_FEND = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	// Configuration registers
	logic [RATE_W-1:0]  turn_rate_q;
	logic [TOL_W-1:0]   angle_tol_q;
	logic [SCALE_W-1:0] dist_scale_q;
	logic [THR_W-1:0]   dock_thr_q;
	logic [RATE_W-1:0]  appr_rate_q;

	// Block state
	logic [MODE_W-1:0]  mode_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [DIST_W-1:0]  dist_q;
	logic               seen_q;

	// Sequencer and datapath registers
	logic [3:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PROD_W-1:0]   prod_q;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W-1:0]    dvs_q;
	logic [DEN_W-1:0]    rem_q;
	logic [STEER_QB-1:0] quo_q;
	logic                skip_q;
	res_t                res_q;

	// Output register
	logic               out_valid_q;
	res_t               out_q;

	logic accept;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// Result moves into the output register this cycle
	logic handoff;
	assign handoff = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Angle magnitude and sign
	logic [ANGLE_W-1:0] mag;
	logic               ang_pos;
	assign mag     = angle_q[ANGLE_W-1] ? ANGLE_W'(-angle_q) : angle_q;
	assign ang_pos = !angle_q[ANGLE_W-1] && (angle_q != '0);

	// Shared multiplier
	logic [15:0] mul_a;
	logic [15:0] mul_b;
	logic [31:0] mul_full;
	always_comb begin
		case (state_q)
			ST_MUL1: begin
				mul_a = dist_q;
				mul_b = 16'(dist_scale_q);
			end
			ST_DEN: begin
				mul_a = mag;
				mul_b = 16'(turn_rate_q);
			end
			ST_SSAT: begin
				mul_a = 16'(appr_rate_q);
				mul_b = dist_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_full = 32'(mul_a) * 32'(mul_b);

	// Steering numerator split into high part and the bits shifted in
	logic [NUM_W-1:0]    num;
	logic [STEER_QB-1:0] num_lo;
	logic [DEN_W-1:0]    num_hi;
	assign num    = {prod_q, {FRAC_BITS{1'b0}}};
	assign num_lo = num[STEER_QB-1:0];
	assign num_hi = DEN_W'(num[NUM_W-1:STEER_QB]);

	// Shared subtractor
	logic [SUB_W-1:0] sub_a;
	logic [SUB_W-1:0] sub_b;
	logic [SUB_W:0]   diff;
	logic             borrow;
	always_comb begin
		case (state_q)
			ST_CMP: begin
				sub_a = SUB_W'(den_q);
				sub_b = SUB_W'({mag, {FRAC_BITS{1'b0}}});
			end
			ST_OVF: begin
				sub_a = SUB_W'(num_hi);
				sub_b = SUB_W'(den_q);
			end
			ST_SDIV, ST_FDIV: begin
				sub_a = {rem_q, quo_q[STEER_QB-1]};
				sub_b = SUB_W'(dvs_q);
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end
	assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow = diff[SUB_W];

	// Saturated steering value from the finished quotient
	logic [TURN_W-1:0] steer_sat;
	always_comb begin
		if (ang_pos) begin
			steer_sat = (quo_q > STEER_QB'(32767)) ? 16'h7FFF : quo_q[TURN_W-1:0];
		end else begin
			steer_sat = (quo_q > STEER_QB'(32768)) ? 16'h8000 : TURN_W'(-quo_q[TURN_W-1:0]);
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_rate_q  <= RST_TURN_RATE;
			angle_tol_q  <= RST_ANGLE_TOLERANCE;
			dist_scale_q <= RST_DISTANCE_SCALE;
			dock_thr_q   <= RST_DOCK_THRESHOLD;
			appr_rate_q  <= RST_APPROACH_RATE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TURN_RATE:       turn_rate_q  <= cfg_data[RATE_W-1:0];
				REG_ANGLE_TOLERANCE: angle_tol_q  <= cfg_data[TOL_W-1:0];
				REG_DISTANCE_SCALE:  dist_scale_q <= cfg_data[SCALE_W-1:0];
				REG_DOCK_THRESHOLD:  dock_thr_q   <= cfg_data[THR_W-1:0];
				REG_APPROACH_RATE:   appr_rate_q  <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, held state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			mode_q      <= MODE_DISABLED;
			angle_q     <= '0;
			dist_q      <= '0;
			seen_q      <= 1'b0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once taken
			if (out_valid_q && !out_stall && !handoff) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_ENABLE: begin
								mode_q <= enable_flag ? MODE_CENTERING : MODE_DISABLED;
							end
							OP_MEASURE: begin
								seen_q <= marker_seen;
								if (marker_seen) begin
									angle_q <= marker_angle;
									dist_q  <= marker_distance;
								end
							end
							OP_TICK: begin
								res_q.fwd <= '0;
								res_q.cv  <= (mode_q != MODE_DISABLED);
								case (mode_q)
									MODE_DISABLED: begin
										res_q.mode <= MODE_DISABLED;
										res_q.turn <= '0;
										state_q    <= ST_DONE;
									end
									MODE_DOCKED: begin
										res_q.mode <= MODE_DISABLED;
										res_q.turn <= '0;
										state_q    <= ST_DONE;
									end
									MODE_CENTERING: begin
										res_q.mode <= MODE_CENTERING;
										if (!seen_q) begin
											res_q.turn <= TURN_W'(turn_rate_q);
											state_q    <= ST_DONE;
										end else begin
											res_q.turn <= ang_pos ? TURN_W'(-{1'b0, turn_rate_q})
											                      : TURN_W'(turn_rate_q);
											state_q    <= ST_MUL1;
										end
									end
									default: begin
										state_q <= ST_MUL1;
									end
								endcase
							end
							default: ;
						endcase
					end
				end
				// distance times scale
				ST_MUL1: begin
					prod_q  <= mul_full[PROD_W-1:0];
					state_q <= ST_DEN;
				end
				// form the shared denominator, start angle times rate
				ST_DEN: begin
					den_q   <= DEN_W'(prod_q[28:0]) + DEN_W'({angle_tol_q, {FRAC_BITS{1'b0}}});
					prod_q  <= mul_full[PROD_W-1:0];
					state_q <= (mode_q == MODE_CENTERING) ? ST_CMP : ST_OVF;
				end
				// centering: advance to approach when within tolerance
				ST_CMP: begin
					if (!borrow) begin
						res_q.mode <= MODE_APPROACH;
					end
					state_q <= ST_DONE;
				end
				// steering: zero, overflow, or start the division
				ST_OVF: begin
					if (prod_q == '0) begin
						res_q.turn <= '0;
						skip_q     <= 1'b1;
						state_q    <= ST_SSAT;
					end else if (!borrow) begin
						res_q.turn <= ang_pos ? 16'h7FFF : 16'h8000;
						skip_q     <= 1'b1;
						state_q    <= ST_SSAT;
					end else begin
						rem_q   <= num_hi;
						quo_q   <= num_lo;
						dvs_q   <= den_q;
						cnt_q   <= CNT_W'(STEER_QB);
						skip_q  <= 1'b0;
						state_q <= ST_SDIV;
					end
				end
				// one restoring step: keep the shifted remainder on a borrow
				ST_SDIV, ST_FDIV: begin
					rem_q <= borrow ? sub_a[DEN_W-1:0] : diff[DEN_W-1:0];
					quo_q <= {quo_q[STEER_QB-2:0], !borrow};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= (state_q == ST_SDIV) ? ST_SSAT : ST_FEND;
					end
				end
				// hold steering result, forward product and divisor
				ST_SSAT: begin
					if (!skip_q) begin
						res_q.turn <= steer_sat;
					end
					prod_q  <= mul_full[PROD_W-1:0];
					dvs_q   <= DEN_W'(17'(dist_q) + 17'(dist_scale_q) + 17'd1);
					state_q <= ST_FSET;
				end
				ST_FSET: begin
					rem_q   <= DEN_W'(prod_q[PROD_W-1:FWD_QB]);
					quo_q   <= {prod_q[FWD_QB-1:0], {(STEER_QB-FWD_QB){1'b0}}};
					cnt_q   <= CNT_W'(FWD_QB);
					state_q <= ST_FDIV;
				end
				ST_FEND: begin
					res_q.fwd  <= quo_q[FWD_W-1:0];
					res_q.mode <= (dist_q > dock_thr_q) ? MODE_APPROACH : MODE_DOCKED;
					state_q    <= ST_DONE;
				end
				// hand the result to the output register when it frees
				ST_DONE: begin
					if (handoff) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						mode_q      <= res_q.mode;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign mode          = out_q.mode;
	assign forward_speed = out_q.fwd;
	assign turn_speed    = out_q.turn;
	assign command_valid = out_q.cv;

`ifndef SYNTH
	// a new result only comes from the hand-off state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside hand-off");

	// the divider remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SDIV || state_q == ST_FDIV) |-> (rem_q < dvs_q))
		else $error("divider remainder out of range");

	// divider never runs with an empty step count
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SDIV || state_q == ST_FDIV) |-> (cnt_q != '0))
		else $error("divider step count exhausted");

	// no command only when the tick started disabled
	a_cv_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !command_valid) |-> (mode == MODE_DISABLED && turn_speed == '0))
		else $error("idle result carries speed or mode");

	// forward motion only from an approach tick
	a_fwd_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && forward_speed != '0) |->
		(mode == MODE_APPROACH || mode == MODE_DOCKED))
		else $error("forward speed outside approach");
`endif

endmodule

### tb/fds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_tick_checker
// Watches the request, result and configuration ports of the docking
// sequencer, predicts the result of every accepted tick and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fds_tick_checker
	import fds_pkg::*;
#(
	parameter int FRAC_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [OP_W-1:0]       op,
	input  logic                  enable_flag,
	input  logic [ANGLE_W-1:0]    marker_angle,
	input  logic [DIST_W-1:0]     marker_distance,
	input  logic                  marker_seen,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [MODE_W-1:0]     mode,
	input  logic [FWD_W-1:0]      forward_speed,
	input  logic [TURN_W-1:0]     turn_speed,
	input  logic                  command_valid,
	output int                    fail_count,
	output int                    results_due
);

	// Predicted sequencer state and register copies
	logic [MODE_W-1:0]  dock_mode;
	logic [ANGLE_W-1:0] held_angle;
	logic [DIST_W-1:0]  held_distance;
	logic               held_seen;
	int                 rate_reg;
	int                 tol_reg;
	int                 scale_reg;
	int                 thr_reg;
	int                 ramp_reg;

	res_t               tick_results_due[$];
	int                 fails;

	// Apply one register write
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_TURN_RATE:       rate_reg  = val[RATE_W-1:0];
			REG_ANGLE_TOLERANCE: tol_reg   = val[TOL_W-1:0];
			REG_DISTANCE_SCALE:  scale_reg = val[SCALE_W-1:0];
			REG_DOCK_THRESHOLD:  thr_reg   = val[THR_W-1:0];
			REG_APPROACH_RATE:   ramp_reg  = val[RATE_W-1:0];
			default: ;
		endcase
	endtask

	// Advance the sequencer by one request; queue the result of a tick
	task automatic advance_sequencer(input logic [OP_W-1:0] rop, input logic ren,
			input logic [ANGLE_W-1:0] rang, input logic [DIST_W-1:0] rdist,
			input logic rseen);
		res_t        r;
		int          ang_i;
		int          turn_i;
		logic [63:0] mag;
		logic [63:0] span;
		logic [63:0] num;
		logic [63:0] quo;
		logic [63:0] fwd_q;
		case (rop)
			OP_ENABLE: dock_mode = ren ? MODE_CENTERING : MODE_DISABLED;
			OP_MEASURE: begin
				held_seen = rseen;
				if (rseen) begin
					held_angle    = rang;
					held_distance = rdist;
				end
			end
			OP_TICK: begin
				r.fwd  = '0;
				r.cv   = 1'b1;
				turn_i = 0;
				ang_i  = $signed(held_angle);
				mag    = (ang_i < 0) ? -ang_i : ang_i;
				span   = 64'(held_distance) * 64'(scale_reg) + (64'(tol_reg) << FRAC_BITS);
				case (dock_mode)
					MODE_CENTERING: begin
						if (!held_seen) begin
							turn_i = rate_reg;
						end else begin
							turn_i = (ang_i > 0) ? -rate_reg : rate_reg;
							if ((mag << FRAC_BITS) <= span)
								dock_mode = MODE_APPROACH;
						end
					end
					MODE_APPROACH: begin
						// steer toward the marker, saturate to the turn width
						num = (mag * 64'(rate_reg)) << FRAC_BITS;
						if (num == 0) begin
							turn_i = 0;
						end else if (span == 0) begin
							turn_i = (ang_i > 0) ? 32767 : -32768;
						end else begin
							quo = num / span;
							if (ang_i > 0)
								turn_i = (quo > 32767) ? 32767 : int'(quo[31:0]);
							else
								turn_i = (quo > 32768) ? -32768 : -int'(quo[31:0]);
						end
						// taper forward speed with distance
						fwd_q = (64'(ramp_reg) * 64'(held_distance))
							/ (64'(held_distance) + 64'(scale_reg) + 64'd1);
						r.fwd = fwd_q[FWD_W-1:0];
						dock_mode = (int'(held_distance) > thr_reg) ? MODE_APPROACH : MODE_DOCKED;
					end
					MODE_DOCKED: dock_mode = MODE_DISABLED;
					default: begin
						dock_mode = MODE_DISABLED;
						r.cv = 1'b0;
					end
				endcase
				r.mode = dock_mode;
				r.turn = turn_i[TURN_W-1:0];
				tick_results_due.push_back(r);
			end
			default: ;
		endcase
	endtask

	// Compare one delivered result against the oldest prediction
	task automatic check_result(input res_t got);
		res_t want;
		if (tick_results_due.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("%0t: result with none due: mode %0d fwd %0d turn %0d cv %0d",
					$time, got.mode, got.fwd, $signed(got.turn), got.cv);
			return;
		end
		want = tick_results_due.pop_front();
		if (got.mode !== want.mode || got.fwd !== want.fwd || got.turn !== want.turn
				|| got.cv !== want.cv) begin
			fails++;
			if (fails <= 10)
				$display("%0t: mismatch: want mode %0d fwd %0d turn %0d cv %0d, got mode %0d fwd %0d turn %0d cv %0d",
					$time, want.mode, want.fwd, $signed(want.turn), want.cv,
					got.mode, got.fwd, $signed(got.turn), got.cv);
		end
	endtask

	// Track accepted writes, requests and results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dock_mode     = MODE_DISABLED;
			held_angle    = '0;
			held_distance = '0;
			held_seen     = 1'b0;
			rate_reg      = RST_TURN_RATE;
			tol_reg       = RST_ANGLE_TOLERANCE;
			scale_reg     = RST_DISTANCE_SCALE;
			thr_reg       = RST_DOCK_THRESHOLD;
			ramp_reg      = RST_APPROACH_RATE;
			fails         = 0;
			tick_results_due.delete();
			fail_count  <= 0;
			results_due <= 0;
		end else begin
			if (cfg_we)
				write_register(cfg_index, cfg_data);
			if (out_valid && !out_stall)
				check_result({mode, forward_speed, turn_speed, command_valid});
			if (in_valid && !in_stall)
				advance_sequencer(op, enable_flag, marker_angle, marker_distance, marker_seen);
			fail_count  <= fails;
			results_due <= tick_results_due.size();
		end
	end

endmodule

### tb/fiducial_docking_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fiducial_docking_sequencer_core_tb
// Drives the docking sequencer through a directed opening and then random
// docking runs mixed with noise requests, over several register settings
// and idling patterns; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module fiducial_docking_sequencer_core_tb;
	import fds_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [OP_W-1:0]       op;
	logic                  enable_flag;
	logic [ANGLE_W-1:0]    marker_angle;
	logic [DIST_W-1:0]     marker_distance;
	logic                  marker_seen;
	logic                  out_valid;
	logic                  out_stall;
	logic [MODE_W-1:0]     mode;
	logic [FWD_W-1:0]      forward_speed;
	logic [TURN_W-1:0]     turn_speed;
	logic                  command_valid;

	int fail_count;
	int results_due;
	int gap_pct;
	int stall_pct;
	int requests_sent;

	// Current register values, used to aim the stimulus
	int cfg_tol;
	int cfg_scale;
	int cfg_thr;

	fiducial_docking_sequencer_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.enable_flag     (enable_flag),
		.marker_angle    (marker_angle),
		.marker_distance (marker_distance),
		.marker_seen     (marker_seen),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.mode            (mode),
		.forward_speed   (forward_speed),
		.turn_speed      (turn_speed),
		.command_valid   (command_valid)
	);

	fds_tick_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.enable_flag     (enable_flag),
		.marker_angle    (marker_angle),
		.marker_distance (marker_distance),
		.marker_seen     (marker_seen),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.mode            (mode),
		.forward_speed   (forward_speed),
		.turn_speed      (turn_speed),
		.command_valid   (command_valid),
		.fail_count      (fail_count),
		.results_due     (results_due)
	);

	// Clock: 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Random receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Give up after a generous fixed time
	initial begin
		#10_000_000;
		$display("fiducial_docking_sequencer_core test failed");
		$finish;
	end

	function automatic logic [15:0] rand16();
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic rand1();
		return 1'($urandom_range(0, 1));
	endfunction

	// Present one request, with random gaps before it, and hold until taken
	task automatic send_request(input logic [OP_W-1:0] rop, input logic ren,
			input logic [ANGLE_W-1:0] rang, input logic [DIST_W-1:0] rdist,
			input logic rseen);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		op              <= rop;
		enable_flag     <= ren;
		marker_angle    <= rang;
		marker_distance <= rdist;
		marker_seen     <= rseen;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (rop != OP_UNUSED)
			requests_sent++;
	endtask

	task automatic noise_request();
		send_request(OP_W'($urandom_range(0, 3)), rand1(), rand16(), rand16(), rand1());
	endtask

	// Drop valid, wait for every due result, then let the block settle
	task automatic settle_idle(input int cycles);
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		@(posedge clk);
	endtask

	// Write all five registers; keep masked copies of tolerance, scale and threshold for aiming
	task automatic load_config(input int rate, input int tol, input int scale,
			input int thr, input int ramp);
		write_reg(REG_TURN_RATE, rate);
		write_reg(REG_ANGLE_TOLERANCE, tol);
		write_reg(REG_DISTANCE_SCALE, scale);
		write_reg(REG_DOCK_THRESHOLD, thr);
		write_reg(REG_APPROACH_RATE, ramp);
		cfg_we    <= 1'b0;
		cfg_tol   = tol & 16'hFFFF;
		cfg_scale = scale & 13'h1FFF;
		cfg_thr   = thr & 16'hFFFF;
	endtask

	// Distance above the dock threshold, often close to it
	function automatic logic [15:0] far_distance();
		int top;
		if (cfg_thr >= 65535)
			return rand16();
		top = ($urandom_range(0, 1) == 0 && cfg_thr + 2000 < 65535) ? cfg_thr + 2000 : 65535;
		return 16'($urandom_range(cfg_thr + 1, top));
	endfunction

	// Angle mostly inside the centering window for this distance
	function automatic logic [15:0] aim_angle(input logic [15:0] mdist);
		int lim;
		int mag;
		if ($urandom_range(0, 5) == 0)
			return rand16();
		lim = cfg_tol + ((int'(mdist) * cfg_scale) >>> 12);
		if (lim > 32767)
			lim = 32767;
		mag = $urandom_range(0, lim);
		return rand1() ? 16'(-mag) : 16'(mag);
	endfunction

	// One docking attempt: enable, center, approach, dock, fall back
	task automatic dock_run();
		logic [15:0] mdist;
		int          steps;
		int          k;
		send_request(OP_ENABLE, 1'b1, rand16(), rand16(), rand1());
		if ($urandom_range(0, 2) == 0) begin
			send_request(OP_MEASURE, rand1(), rand16(), rand16(), 1'b0);
			send_request(OP_TICK, rand1(), rand16(), rand16(), rand1());
		end
		mdist = far_distance();
		send_request(OP_MEASURE, rand1(), aim_angle(mdist), mdist, 1'b1);
		repeat ($urandom_range(1, 2))
			send_request(OP_TICK, rand1(), rand16(), rand16(), rand1());
		steps = $urandom_range(0, 4);
		for (k = 0; k < steps; k++) begin
			if ($urandom_range(0, 9) == 0)
				noise_request();
			if ($urandom_range(0, 11) == 0)
				send_request(OP_ENABLE, rand1(), rand16(), rand16(), rand1());
			mdist = far_distance();
			send_request(OP_MEASURE, rand1(), aim_angle(mdist), mdist, 1'b1);
			send_request(OP_TICK, rand1(), rand16(), rand16(), rand1());
		end
		mdist = 16'($urandom_range(0, cfg_thr));
		send_request(OP_MEASURE, rand1(), aim_angle(mdist), mdist, 1'b1);
		send_request(OP_TICK, rand1(), rand16(), rand16(), rand1());
		send_request(OP_TICK, rand1(), rand16(), rand16(), rand1());
		if (rand1())
			send_request(OP_TICK, rand1(), rand16(), rand16(), rand1());
	endtask

	// Walk every mode and edge value under the reset registers
	task automatic directed_requests();
		send_request(OP_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
		send_request(OP_MEASURE, 1'b1, 16'h7FFF, 16'hFFFF, 1'b0);
		send_request(OP_ENABLE, 1'b1, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_MEASURE, 1'b0, 16'h7FFF, 16'hFFFF, 1'b1);
		send_request(OP_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_MEASURE, 1'b0, 16'h8000, 16'h0000, 1'b1);
		send_request(OP_MEASURE, 1'b1, 16'h1234, 16'h4321, 1'b0);
		send_request(OP_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_ENABLE, 1'b1, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_MEASURE, 1'b0, 16'h0000, 16'd205, 1'b1);
		send_request(OP_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_ENABLE, 1'b1, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_ENABLE, 1'b0, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_ENABLE, 1'b1, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_MEASURE, 1'b0, 16'h0001, 16'd206, 1'b1);
		send_request(OP_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0);
		send_request(OP_ENABLE, 1'b0, 16'h0000, 16'h0000, 1'b0);
	endtask

	// Stimulus: six segments, each with its own registers and idling
	initial begin
		int seg;
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_TURN_RATE;
		cfg_data        = '0;
		in_valid        = 1'b0;
		op              = OP_TICK;
		enable_flag     = 1'b0;
		marker_angle    = '0;
		marker_distance = '0;
		marker_seen     = 1'b0;
		out_stall       = 1'b0;
		gap_pct         = 6;
		stall_pct       = 56;
		requests_sent   = 0;
		cfg_tol         = RST_ANGLE_TOLERANCE;
		cfg_scale       = RST_DISTANCE_SCALE;
		cfg_thr         = RST_DOCK_THRESHOLD;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin
					gap_pct   = 6;
					stall_pct = 56;
				end
				1: begin
					gap_pct   = 56;
					stall_pct = 6;
				end
				default: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
			endcase
			if (seg > 0)
				settle_idle(50);
			case (seg)
				0: directed_requests();
				1: load_config(32767, 65535, 4096, 65535, 32767);
				2: load_config(0, 1, 0, 0, 0);
				// zero tolerance: steering divisor vanishes at distance zero
				3: load_config(32767, 0, 4096, 300, 32767);
				// every bit set, beyond the stated ranges
				4: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				default: load_config($urandom_range(0, 32767), $urandom_range(1, 65535),
					$urandom_range(0, 4096), $urandom_range(0, 65535),
					$urandom_range(0, 32767));
			endcase
			while (requests_sent < (seg + 1) * 192) begin
				if ($urandom_range(0, 4) == 0)
					noise_request();
				else
					dock_run();
			end
		end

		settle_idle(60);
		if (fail_count == 0)
			$display("fiducial_docking_sequencer_core test passed");
		else
			$display("fiducial_docking_sequencer_core test failed");
		$finish;
	end

endmodule
